// ===== sv/htd_pkg.sv =====
package htd_pkg;

    // Field and state widths
    localparam int COUNT_BITS = 24;
    localparam int TICK_BITS  = 14;
    localparam int ANGLE_W    = 24;
    localparam int ZONE_W     = 3;
    localparam int DUTY_W     = 10;

    // Stream packing
    localparam int S_TDATA_W    = ((TICK_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ZONE_W + DUTY_W + 1 + ANGLE_W + 1;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W      = M_TDATA_W - OUT_FIELDS_W;

    // Count to Q.8 degrees: count * round(2^24 / 714.15) >>> 16
    localparam int DEG_SCALE  = 23493;
    localparam int SCALE_W    = 16;
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_W     = COUNT_BITS + SCALE_W;
    localparam int ANG_EXT_W  = (COUNT_BITS > ANGLE_W) ? COUNT_BITS : ANGLE_W;

    // Zone half widths in Q.8: 4 degrees, bump 2 degrees
    localparam int ZONE_HALF   = 1024;
    localparam int BUMP_HALF   = 512;
    localparam int NUM_CENTERS = 5;

    // APB
    localparam int PADDR_W      = 5;
    localparam int CFG_ADDR_LSB = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int PDATA_W      = 32;

    localparam logic [DUTY_W-1:0] DUTY_OFF         = DUTY_W'(0);
    localparam logic [DUTY_W-1:0] DUTY_LIGHT_STICK = DUTY_W'(650);
    localparam logic [DUTY_W-1:0] DUTY_HEAVY_STICK = DUTY_W'(950);
    localparam logic [DUTY_W-1:0] DUTY_LIGHT_SLIP  = DUTY_W'(650);
    localparam logic [DUTY_W-1:0] DUTY_HEAVY_SLIP  = DUTY_W'(850);
    localparam logic [DUTY_W-1:0] DUTY_BUMP        = DUTY_W'(550);

    typedef logic signed [ANGLE_W-1:0] q8_t;
    typedef logic [NUM_CENTERS-1:0][ANGLE_W-1:0] centers_t;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_NONE        = 3'd0,
        ZONE_LIGHT_STICK = 3'd1,
        ZONE_HEAVY_STICK = 3'd2,
        ZONE_LIGHT_SLIP  = 3'd3,
        ZONE_HEAVY_SLIP  = 3'd4,
        ZONE_BUMP        = 3'd5
    } zone_t;

    // Register indexes, also the center slots in priority order
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_STICK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAVY_STICK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_SLIP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAVY_SLIP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUMP        = 3'd4;

    typedef struct packed {
        zone_t             zone;
        logic [DUTY_W-1:0] duty;
        logic              drive_dir;
    } zone_res_t;

endpackage

// ===== sv/htd_zone.sv =====
module htd_zone
    import htd_pkg::*;
(
    input  q8_t       angle,
    input  centers_t  centers,
    input  logic      motion_dir,
    input  logic      drive_dir,
    output zone_res_t res
);

    localparam logic signed [ANGLE_W:0] ZH = (ANGLE_W + 1)'(ZONE_HALF);
    localparam logic signed [ANGLE_W:0] BH = (ANGLE_W + 1)'(BUMP_HALF);

    logic signed [ANGLE_W:0] diff [NUM_CENTERS];
    logic [NUM_CENTERS-1:0]  hit;

    // Strict window test on angle - center, one spare bit for the subtract
    always_comb begin
        for (int i = 0; i < NUM_CENTERS; i++) begin
            diff[i] = (ANGLE_W + 1)'(angle) - (ANGLE_W + 1)'($signed(centers[i]));
            if (i == NUM_CENTERS - 1) begin
                hit[i] = (diff[i] > -BH) && (diff[i] < BH);
            end else begin
                hit[i] = (diff[i] > -ZH) && (diff[i] < ZH);
            end
        end
    end

    always_comb begin
        res.zone      = ZONE_NONE;
        res.duty      = DUTY_OFF;
        res.drive_dir = drive_dir;
        priority if (hit[REG_LIGHT_STICK]) begin
            res.zone      = ZONE_LIGHT_STICK;
            res.duty      = DUTY_LIGHT_STICK;
            res.drive_dir = ~drive_dir;
        end else if (hit[REG_HEAVY_STICK]) begin
            res.zone      = ZONE_HEAVY_STICK;
            res.duty      = DUTY_HEAVY_STICK;
            res.drive_dir = ~drive_dir;
        end else if (hit[REG_LIGHT_SLIP]) begin
            res.zone      = ZONE_LIGHT_SLIP;
            res.duty      = DUTY_LIGHT_SLIP;
            res.drive_dir = motion_dir;
        end else if (hit[REG_HEAVY_SLIP]) begin
            res.zone      = ZONE_HEAVY_SLIP;
            res.duty      = DUTY_HEAVY_SLIP;
            res.drive_dir = motion_dir;
        end else if (hit[REG_BUMP]) begin
            res.zone      = ZONE_BUMP;
            res.duty      = DUTY_BUMP;
            res.drive_dir = ~drive_dir;
        end else begin
            res.zone      = ZONE_NONE;
        end
    end

endmodule

// ===== sv/haptic_texture_encoder_drive.sv =====
// Haptic texture drive: encoder unwrap, position count and zone lookup.
//
// Input stream (s_*): one beat per absolute encoder reading, ticks in
// s_tdata[13:0]. Result stream (m_*): one beat per input beat, in order,
// carrying zone, duty in thousandths, drive direction, the Q.8 angle and
// a flag that the position count clamped on this beat.
// APB port: five zone centres (signed Q.8 degrees) at byte addresses 0, 4,
// 8, 12, 16; write them only while the block is empty.
//
// A beat goes through stage 1, stage 2 and the output register, at one
// beat per cycle while s_tready is high. Stage 1 does unwrap and the
// saturating accumulate (the count register is fed back to itself each
// beat), stage 2 the scale multiply, stage 3 the angle clamp, the five
// window compares and the drive direction update into the output register.
// Each stage has its own valid and loads when empty or draining, so input
// beats keep flowing into empty stages while a result waits on m_tready;
// s_tready drops only when all three stages are full and m_tready is low.
// Reset clears the count, the stored reading, the direction state and the
// centres; the first beat after reset only primes the stored reading
// (step taken as zero) but still gives a result.
module haptic_texture_encoder_drive
    import htd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: ticks [13:0], upper bits ignored
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: zone [2:0], duty_permille [12:3], drive_direction [13],
    //          angle_q8 [37:14], count_saturated [38], zero [39]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam logic signed [TICK_BITS+1:0] T_HALF = (TICK_BITS + 2)'(2 ** (TICK_BITS - 1));
    localparam logic signed [TICK_BITS+1:0] T_WRAP = (TICK_BITS + 2)'(2 ** TICK_BITS);
    localparam logic signed [COUNT_BITS:0]  SUM_MAX = {2'b00, {(COUNT_BITS - 1){1'b1}}};
    localparam logic signed [COUNT_BITS:0]  SUM_MIN = {2'b11, {(COUNT_BITS - 1){1'b0}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};
    localparam logic signed [SCALE_W-1:0]   SCALE_S = SCALE_W'(DEG_SCALE);
    localparam logic signed [ANG_EXT_W-1:0] ANG_MAX =
        ANG_EXT_W'($signed({1'b0, {(ANGLE_W - 1){1'b1}}}));
    localparam logic signed [ANG_EXT_W-1:0] ANG_MIN =
        ANG_EXT_W'($signed({1'b1, {(ANGLE_W - 1){1'b0}}}));

    // Configuration
    centers_t              centers_reg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic                  cfg_wr;

    // Stage 1: holds the position count and motion direction state
    logic                         v1_reg;
    logic                         primed_reg;
    logic [TICK_BITS-1:0]         last_ticks_reg;
    logic signed [COUNT_BITS-1:0] s1_count_reg;
    logic                         s1_sat_reg;
    logic                         s1_mdir_reg;

    // Stage 2: scaled product
    logic                     v2_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic                     s2_sat_reg;
    logic                     s2_mdir_reg;

    // Output register
    logic                m_tvalid_reg;
    zone_t               m_zone_reg;
    logic [DUTY_W-1:0]   m_duty_reg;
    logic                m_dir_reg;
    q8_t                 m_angle_reg;
    logic                m_sat_reg;
    logic                drive_dir_reg;

    logic ready3;
    logic ready2;
    logic s_accept;

    logic [TICK_BITS-1:0]         ticks;
    logic signed [TICK_BITS+1:0]  d_raw;
    logic signed [TICK_BITS:0]    step;
    logic signed [COUNT_BITS:0]   sum;
    logic signed [COUNT_BITS-1:0] count_next;
    logic                         sat_next;
    logic                         mdir_next;

    logic signed [COUNT_BITS-1:0] shifted;
    logic signed [ANG_EXT_W-1:0]  ang_ext;
    q8_t                          angle;
    zone_res_t                    zres;

    // ---------------- APB ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_LSB +: CFG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (cfg_idx <= REG_BUMP) begin
            prdata = PDATA_W'($signed(centers_reg[cfg_idx]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centers_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LIGHT_STICK: centers_reg[REG_LIGHT_STICK] <= pwdata[ANGLE_W-1:0];
                REG_HEAVY_STICK: centers_reg[REG_HEAVY_STICK] <= pwdata[ANGLE_W-1:0];
                REG_LIGHT_SLIP:  centers_reg[REG_LIGHT_SLIP]  <= pwdata[ANGLE_W-1:0];
                REG_HEAVY_SLIP:  centers_reg[REG_HEAVY_SLIP]  <= pwdata[ANGLE_W-1:0];
                REG_BUMP:        centers_reg[REG_BUMP]        <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign ready3   = !m_tvalid_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign s_tready = !v1_reg || ready2;
    assign s_accept = s_tvalid && s_tready;

    // ---------------- stage 1: unwrap and accumulate ----------------
    assign ticks = s_tdata[TICK_BITS-1:0];
    assign d_raw = $signed({2'b00, ticks}) - $signed({2'b00, last_ticks_reg});

    always_comb begin
        step      = '0;
        mdir_next = s1_mdir_reg;
        if (primed_reg) begin
            priority if (d_raw > T_HALF) begin
                step = (TICK_BITS + 1)'(d_raw - T_WRAP);
            end else if (d_raw < -T_HALF) begin
                step = (TICK_BITS + 1)'(d_raw + T_WRAP);
            end else begin
                step = (TICK_BITS + 1)'(d_raw);
            end
            priority if (ticks > last_ticks_reg) begin
                mdir_next = 1'b0;
            end else if (ticks < last_ticks_reg) begin
                mdir_next = 1'b1;
            end else begin
                mdir_next = s1_mdir_reg;
            end
        end
        sum = (COUNT_BITS + 1)'(s1_count_reg) + (COUNT_BITS + 1)'(step);
        priority if (sum > SUM_MAX) begin
            count_next = CNT_MAX;
            sat_next   = 1'b1;
        end else if (sum < SUM_MIN) begin
            count_next = CNT_MIN;
            sat_next   = 1'b1;
        end else begin
            count_next = sum[COUNT_BITS-1:0];
            sat_next   = 1'b0;
        end
    end

    // ---------------- stage 3: angle clamp and zones ----------------
    assign shifted = s2_prod_reg[PROD_W-1:FRAC_SHIFT];
    assign ang_ext = ANG_EXT_W'(shifted);

    always_comb begin
        priority if (ang_ext > ANG_MAX) begin
            angle = ANG_MAX[ANGLE_W-1:0];
        end else if (ang_ext < ANG_MIN) begin
            angle = ANG_MIN[ANGLE_W-1:0];
        end else begin
            angle = ang_ext[ANGLE_W-1:0];
        end
    end

    htd_zone u_zone (
        .angle      (angle),
        .centers    (centers_reg),
        .motion_dir (s2_mdir_reg),
        .drive_dir  (drive_dir_reg),
        .res        (zres)
    );

    // ---------------- control and state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            primed_reg     <= 1'b0;
            last_ticks_reg <= '0;
            s1_count_reg   <= '0;
            s1_mdir_reg    <= 1'b0;
            drive_dir_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                m_tvalid_reg <= v2_reg;
            end
            if (s_accept) begin
                primed_reg     <= 1'b1;
                last_ticks_reg <= ticks;
                s1_count_reg   <= count_next;
                s1_mdir_reg    <= mdir_next;
            end
            if (ready3 && v2_reg) begin
                drive_dir_reg <= zres.drive_dir;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_sat_reg <= sat_next;
        end
        if (ready2 && v1_reg) begin
            s2_prod_reg <= PROD_W'(s1_count_reg) * PROD_W'(SCALE_S);
            s2_sat_reg  <= s1_sat_reg;
            s2_mdir_reg <= s1_mdir_reg;
        end
        if (ready3 && v2_reg) begin
            m_zone_reg  <= zres.zone;
            m_duty_reg  <= zres.duty;
            m_dir_reg   <= zres.drive_dir;
            m_angle_reg <= angle;
            m_sat_reg   <= s2_sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_sat_reg, m_angle_reg, m_dir_reg, m_duty_reg,
                       m_zone_reg};

    // ---------------- assertions ----------------
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && v2_reg && v1_reg))
        else $error("input stalled with an empty stage");

    a_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> primed_reg)
        else $error("not primed after an accepted beat");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && s1_sat_reg) |-> (s1_count_reg == CNT_MAX || s1_count_reg == CNT_MIN))
        else $error("saturation flag without count at a limit");

    a_duty_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ((m_zone_reg == ZONE_NONE) == (m_duty_reg == DUTY_OFF)))
        else $error("duty does not match zone");

    a_dir_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (ready3 && v2_reg && zres.zone == ZONE_NONE) |=>
            (drive_dir_reg == $past(drive_dir_reg)))
        else $error("drive direction changed outside any zone");

endmodule

// ===== verif/tb.sv =====
module tb
    import htd_pkg::*;
();

    // Generous ceiling: roughly 750 beats, with both sides idling,
    // plus config traffic.
    localparam int LIMIT_CYCLES = 100000;

    localparam int TICK_WRAP = 1 << TICK_BITS;
    localparam int TICK_HALF = 1 << (TICK_BITS - 1);
    localparam longint COUNT_MAX = (longint'(1) <<< (COUNT_BITS - 1)) - 1;
    localparam longint COUNT_MIN = -(longint'(1) <<< (COUNT_BITS - 1));
    localparam longint ANGLE_MAX = (longint'(1) <<< (ANGLE_W - 1)) - 1;
    localparam longint ANGLE_MIN = -(longint'(1) <<< (ANGLE_W - 1));

    // How the zone centres are placed for a phase
    typedef enum int {
        CTR_SPREAD,
        CTR_STACKED,
        CTR_EXTREME
    } centre_mode_t;

    // Result beat, laid out MSB first so that it casts straight from m_tdata
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic               sat;
        logic [ANGLE_W-1:0] angle;
        logic               drive_dir;
        logic [DUTY_W-1:0]  duty;
        zone_t              zone;
    } drive_res_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Predictor state, at its reset values
    logic [TICK_BITS-1:0] prev_ticks = '0;
    logic                 primed_q   = 1'b0;
    longint               pos_count  = 0;
    logic                 motion_q   = 1'b0;
    logic                 drive_q    = 1'b0;
    longint               zone_centre [NUM_CENTERS] = '{default: 0};

    logic [S_TDATA_W-1:0] tick_pending [$];
    drive_res_t           drive_expected [$];
    drive_res_t           got_res;
    drive_res_t           want_res;

    int  gen_ticks      = 0;
    int  queued_count   = 0;
    int  accepted_count = 0;
    int  err_count      = 0;
    int  cycle_count    = 0;
    int  idle_pct       = 0;
    int  stall_pct      = 0;
    int  drift          = 0;
    int  s_gap          = 0;
    int  m_gap          = 0;
    bit  s_fire         = 1'b0;

    haptic_texture_encoder_drive i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Count to Q.8 degrees: floor(count * scale / 2^16), clamped to 24 bits
    function automatic longint count_to_angle(input longint cnt);
        longint a;
        a = (cnt * DEG_SCALE) >>> FRAC_SHIFT;
        if (a > ANGLE_MAX) a = ANGLE_MAX;
        if (a < ANGLE_MIN) a = ANGLE_MIN;
        return a;
    endfunction

    // Strict window, both edges excluded
    function automatic bit in_zone(input longint a, input longint c, input longint half);
        return (a > c - half) && (a < c + half);
    endfunction

    task automatic advance_drive(input logic [S_TDATA_W-1:0] beat);
        logic [TICK_BITS-1:0] t;
        longint               step;
        longint               total;
        longint               ang;
        drive_res_t           r;
        t    = beat[TICK_BITS-1:0];
        step = 0;
        r    = '0;
        // first beat after reset only primes the stored reading
        if (primed_q) begin
            step = longint'(t) - longint'(prev_ticks);
            if (step > TICK_HALF) step -= TICK_WRAP;
            if (step < -TICK_HALF) step += TICK_WRAP;
            // motion follows the raw readings, not the unwrapped step
            if (t > prev_ticks) motion_q = 1'b0;
            if (t < prev_ticks) motion_q = 1'b1;
        end
        primed_q   = 1'b1;
        prev_ticks = t;

        total = pos_count + step;
        if (total > COUNT_MAX) begin
            total = COUNT_MAX;
            r.sat = 1'b1;
        end else if (total < COUNT_MIN) begin
            total = COUNT_MIN;
            r.sat = 1'b1;
        end
        pos_count = total;
        ang = count_to_angle(total);

        // priority: light stick, heavy stick, light slip, heavy slip, bump
        r.zone = ZONE_NONE;
        r.duty = DUTY_OFF;
        if (in_zone(ang, zone_centre[REG_LIGHT_STICK], ZONE_HALF)) begin
            r.zone  = ZONE_LIGHT_STICK;
            r.duty  = DUTY_LIGHT_STICK;
            drive_q = ~drive_q;
        end else if (in_zone(ang, zone_centre[REG_HEAVY_STICK], ZONE_HALF)) begin
            r.zone  = ZONE_HEAVY_STICK;
            r.duty  = DUTY_HEAVY_STICK;
            drive_q = ~drive_q;
        end else if (in_zone(ang, zone_centre[REG_LIGHT_SLIP], ZONE_HALF)) begin
            r.zone  = ZONE_LIGHT_SLIP;
            r.duty  = DUTY_LIGHT_SLIP;
            drive_q = motion_q;
        end else if (in_zone(ang, zone_centre[REG_HEAVY_SLIP], ZONE_HALF)) begin
            r.zone  = ZONE_HEAVY_SLIP;
            r.duty  = DUTY_HEAVY_SLIP;
            drive_q = motion_q;
        end else if (in_zone(ang, zone_centre[REG_BUMP], BUMP_HALF)) begin
            r.zone  = ZONE_BUMP;
            r.duty  = DUTY_BUMP;
            drive_q = ~drive_q;
        end
        r.drive_dir = drive_q;
        r.angle     = ang[ANGLE_W-1:0];
        drive_expected.push_back(r);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue an absolute reading; bits above the tick field are junk
    task automatic queue_reading(input int t);
        logic [S_TDATA_W-1:0] beat;
        gen_ticks = t & (TICK_WRAP - 1);
        beat = S_TDATA_W'($urandom);
        beat[TICK_BITS-1:0] = gen_ticks[TICK_BITS-1:0];
        tick_pending.push_back(beat);
        queued_count++;
    endtask

    task automatic queue_step(input int step);
        queue_reading(gen_ticks + step);
    endtask

    // Random walk: mostly small drifting steps, with repeats, the half-wrap
    // boundary, medium moves and fully random readings mixed in
    task automatic queue_wander(input int n);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0:       queue_reading($urandom_range(0, TICK_WRAP - 1));
                1:       queue_step(0);
                2:       queue_step($urandom_range(0, 1) ? TICK_HALF : -TICK_HALF);
                3:       queue_step(int'($urandom_range(0, 16000)) - 8000);
                default: queue_step(drift + int'($urandom_range(0, 400)) - 200);
            endcase
        end
    endtask

    // Block is idle once every queued beat is in and every result is out;
    // then let the pipe settle
    task automatic wait_idle();
        while (accepted_count != queued_count || drive_expected.size() != 0)
            @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    // APB write, then read back. Register lands at the access-phase edge.
    task automatic write_centre(input int idx, input longint value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx << CFG_ADDR_LSB);
        pwdata  <= PDATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        // indexes past the list are ignored by the block
        if (idx < NUM_CENTERS) zone_centre[idx] = $signed(value[ANGLE_W-1:0]);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx < NUM_CENTERS && prdata[ANGLE_W-1:0] !== value[ANGLE_W-1:0]) begin
            $display("%0t: centre %0d readback mismatch, expected %h, actual %h",
                     $time, idx, value[ANGLE_W-1:0], prdata[ANGLE_W-1:0]);
            err_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Place all five centres relative to where the angle sits now, or at the ends of the angle range
    task automatic set_centres(input centre_mode_t mode);
        longint here;
        longint c;
        here = count_to_angle(pos_count);
        for (int i = 0; i < NUM_CENTERS; i++) begin
            case (mode)
                CTR_SPREAD:  c = here + int'($urandom_range(0, 8000)) - 4000;
                // overlapping windows, priority decides
                CTR_STACKED: c = here + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 600));
                default: begin
                    case ($urandom_range(0, 2))
                        0:       c = ANGLE_MIN;
                        1:       c = ANGLE_MAX;
                        default: c = here + int'($urandom_range(0, 4000)) - 2000;
                    endcase
                end
            endcase
            if (c > ANGLE_MAX) c = ANGLE_MAX;
            if (c < ANGLE_MIN) c = ANGLE_MIN;
            write_centre(i, c);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents pending readings, idles in bursts after a beat
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_tvalid || s_fire) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (tick_pending.size() > 0) begin
                s_tdata  <= tick_pending.pop_front();
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 99) < idle_pct) s_gap = $urandom_range(1, 7);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, in bursts
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_gap = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result beats first, then predict for the input beat
    // taken on this edge, so a stray result never meets a fresh expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = drive_res_t'(m_tdata);
            if (drive_expected.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                err_count++;
            end else begin
                want_res = drive_expected.pop_front();
                check_field("zone", want_res.zone, got_res.zone);
                check_field("duty_permille", want_res.duty, got_res.duty);
                check_field("drive_direction", want_res.drive_dir, got_res.drive_dir);
                check_field("angle_q8", want_res.angle, got_res.angle);
                check_field("count_saturated", want_res.sat, got_res.sat);
                check_field("pad", want_res.pad, got_res.pad);
            end
        end
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            advance_drive(s_tdata);
            accepted_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("haptic_texture_encoder_drive test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        longint here;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset centres (all zero): priming beat at top reading,
        // repeat reading, wrap both ways (raw compare disagrees with the
        // unwrapped step), exact half-wrap steps and just past them
        queue_reading(TICK_WRAP - 1);
        queue_reading(TICK_WRAP - 1);
        queue_reading(0);
        queue_reading(TICK_WRAP - 1);
        queue_reading(TICK_HALF - 1);
        queue_reading(TICK_WRAP - 1);
        queue_reading(TICK_HALF - 2);
        queue_reading(0);
        queue_reading(TICK_HALF + 1);
        queue_reading(1);
        queue_reading(2);
        queue_reading(1);
        wait_idle();

        // Directed zone walk: stick windows edge-on to the current angle,
        // bump just above, slips below
        here = count_to_angle(pos_count);
        write_centre(REG_LIGHT_STICK, here + ZONE_HALF);
        write_centre(REG_HEAVY_STICK, here - ZONE_HALF);
        write_centre(REG_LIGHT_SLIP, here - 4 * ZONE_HALF);
        write_centre(REG_HEAVY_SLIP, here - 8 * ZONE_HALF);
        write_centre(REG_BUMP, here + 2 * ZONE_HALF);
        queue_step(0);          // on both stick edges: no zone
        queue_step(3);          // just inside light stick
        queue_step(-6);         // just inside heavy stick
        queue_step(5758);       // bump
        queue_step(3000);       // clear of everything
        repeat (3) queue_step(-5000);
        queue_step(-5000);      // light slip
        repeat (2) queue_step(-5000);   // the second of these lands in heavy slip
        queue_step(1);
        wait_idle();

        // Random phases, each with its own centre layout and idling
        for (int ph = 0; ph < 6; ph++) begin
            set_centres(centre_mode_t'(ph % 3));
            if (ph == 2) write_centre(NUM_CENTERS + $urandom_range(0, 2), $urandom);
            idle_pct  = $urandom_range(0, 2) * 20;
            stall_pct = $urandom_range(0, 2) * 20;
            drift     = int'($urandom_range(0, 300)) - 150;
            queue_wander(70);
            wait_idle();
        end

        // Long strides: run far up, then part way back down. Windows sit at both
        // ends of the angle range, across zero, near the turn and halfway to it.
        here = count_to_angle(pos_count + 150 * 7000);
        write_centre(REG_LIGHT_STICK, ANGLE_MAX);
        write_centre(REG_HEAVY_STICK, ANGLE_MIN);
        write_centre(REG_LIGHT_SLIP, here - 300);
        write_centre(REG_HEAVY_SLIP, 0);
        write_centre(REG_BUMP, here / 2);
        idle_pct  = 5;
        stall_pct = 5;
        repeat (150) queue_step($urandom_range(6000, TICK_HALF - 1));
        repeat (100) queue_step(-int'($urandom_range(6000, TICK_HALF - 1)));
        queue_wander(20);
        wait_idle();

        // Last stretch flat out, no idling on either side
        set_centres(CTR_SPREAD);
        idle_pct  = 0;
        stall_pct = 0;
        drift     = 0;
        queue_wander(40);
        wait_idle();

        if (err_count == 0) begin
            $display("haptic_texture_encoder_drive test passed");
        end else begin
            $display("haptic_texture_encoder_drive test failed");
        end
        $finish;
    end

endmodule
